/* rtl/dvtt_pkg.sv */
package dvtt_pkg;

	// signed day count from 1-Jan-1970
	typedef logic signed [26:0] days_t;
	// signed second count from 1-Jan-1970
	typedef logic signed [43:0] secs_t;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	localparam logic [63:0] EPOCH_TICKS    = 64'h007C_9567_4BEB_4000;
	localparam logic [23:0] TICKS_PER_SEC  = 24'd10000000;
	localparam logic [23:0] TICKS_PER_HUND = 24'd100000;

	// floor(ya / 400) = (ya * ERA_RECIP) >> ERA_SHIFT, exact for ya below 2^17
	localparam logic [17:0] ERA_RECIP     = 18'd167773;
	localparam int          ERA_SHIFT     = 26;
	localparam logic [25:0] DAYS_PER_ERA  = 26'd146097;
	// 1970 offset in days plus the one-era shift applied to the year
	localparam days_t       DAY_BIAS      = 27'sd865565;
	localparam secs_t       SECS_PER_DAY  = 44'sd86400;

	// days before the first of the month, in a year that starts in March
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd3:    d = 9'd0;
			4'd4:    d = 9'd31;
			4'd5:    d = 9'd61;
			4'd6:    d = 9'd92;
			4'd7:    d = 9'd122;
			4'd8:    d = 9'd153;
			4'd9:    d = 9'd184;
			4'd10:   d = 9'd214;
			4'd11:   d = 9'd245;
			4'd12:   d = 9'd275;
			4'd1:    d = 9'd306;
			4'd2:    d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/dvtt_vec_if.sv */
interface dvtt_vec_if;
	logic        valid;
	logic        ready;
	logic [15:0] year;
	logic [15:0] month;
	logic [15:0] day;
	logic [15:0] hour;
	logic [15:0] minute;
	logic [15:0] second;
	logic [15:0] hundredths;

	modport source (
		output valid, year, month, day, hour, minute, second, hundredths,
		input  ready
	);
	modport sink (
		input  valid, year, month, day, hour, minute, second, hundredths,
		output ready
	);
endinterface

/* rtl/dvtt_tick_if.sv */
interface dvtt_tick_if;
	logic        valid;
	logic        ready;
	logic [63:0] tick_time;
	logic        status;

	modport source (
		output valid, tick_time, status,
		input  ready
	);
	modport sink (
		input  valid, tick_time, status,
		output ready
	);
endinterface

/* rtl/date_vector_to_tick_time_unit.sv */
// Time vector to tick time converter.
// The vec channel takes one calendar vector per transaction (year, month, day,
// hour, minute, second, hundredths, each a 16-bit word). The res channel
// returns one result per vector, in order: tick_time, 100 ns ticks since
// 17-Nov-1858 modulo 2^64, and status, which is set (with tick_time zero) when
// a word is out of range or the vector falls on the second just before 1970.
// The datapath is a seven-stage pipeline, and one vector per cycle is taken
// for as long as res is ready. The depth is set by the day count (three
// stages), the seconds multiply, the seconds sum and the 64-bit scaling,
// which is split into two partial products and a final add.
// Each stage advances on its own when the stage after it is empty or moving,
// so bubbles close up while res is stalled; vec.ready drops only once all
// seven stages hold a result. Nothing is lost or repeated across a stall.
// Reset clears all stage valid bits; the data registers have no reset, and the
// block is ready in the first cycle after reset is released.
module date_vector_to_tick_time_unit (
	input  logic              clk,
	input  logic              arst_n,
	dvtt_vec_if.sink          vec,
	dvtt_tick_if.source       res
);
	import dvtt_pkg::*;

	localparam int NSTAGE = 7;

	logic [NSTAGE:1] v_q;
	logic [NSTAGE:1] en;

	logic        bad;
	logic [16:0] hms;
	logic [23:0] hund_ticks;

	logic        bad_s1, bad_s2, bad_s3, bad_s4, bad_s5, bad_s6, bad_s7;
	logic [16:0] hms_s1, hms_s2, hms_s3, hms_s4;
	logic [23:0] hund_s1, hund_s2, hund_s3, hund_s4, hund_s5, hund_s6;

	days_t       days_s3;
	secs_t       prod_s4;
	secs_t       secs_s5;
	logic [45:0] lo_s6;
	logic signed [46:0] hi_s6;
	logic [63:0] tick_s7;

	secs_t       secs;
	logic [63:0] tick;

	// let each stage load when it is empty or the next one is loading
	always_comb begin
		en[NSTAGE] = !v_q[NSTAGE] || res.ready;
		for (int i = NSTAGE - 1; i >= 1; i--)
			en[i] = !v_q[i] || en[i+1];
	end

	assign vec.ready = en[1];

	// move valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= vec.valid;
			for (int i = 2; i <= NSTAGE; i++)
				if (en[i])
					v_q[i] <= v_q[i-1];
		end
	end

	// range checks and time-of-day terms
	always_comb begin
		bad = (vec.month == 16'd0) || (vec.month > 16'd12) ||
		      (vec.day == 16'd0) || (vec.day > 16'd31) ||
		      (vec.hour > 16'd23) || (vec.minute > 16'd59) ||
		      (vec.second > 16'd59) || (vec.hundredths > 16'd99);
		hms = {12'b0, vec.hour[4:0]} * 17'd3600 +
		      {11'b0, vec.minute[5:0]} * 17'd60 +
		      {11'b0, vec.second[5:0]};
		hund_ticks = {17'b0, vec.hundredths[6:0]} * TICKS_PER_HUND;
	end

	dvtt_day_count u_days (
		.clk   (clk),
		.en    (en[3:1]),
		.year  (vec.year),
		.month (vec.month[3:0]),
		.day   (vec.day[4:0]),
		.days  (days_s3)
	);

	// carry side terms alongside the day count
	always_ff @(posedge clk) begin
		if (en[1]) begin
			bad_s1  <= bad;
			hms_s1  <= hms;
			hund_s1 <= hund_ticks;
		end
		if (en[2]) begin
			bad_s2  <= bad_s1;
			hms_s2  <= hms_s1;
			hund_s2 <= hund_s1;
		end
		if (en[3]) begin
			bad_s3  <= bad_s2;
			hms_s3  <= hms_s2;
			hund_s3 <= hund_s2;
		end
	end

	// stage 4: days to seconds
	always_ff @(posedge clk) begin
		if (en[4]) begin
			bad_s4  <= bad_s3;
			hms_s4  <= hms_s3;
			hund_s4 <= hund_s3;
			prod_s4 <= secs_t'(days_s3) * SECS_PER_DAY;
		end
	end

	// stage 5: add time of day, flag the second before the epoch
	assign secs = prod_s4 + $signed({27'b0, hms_s4});

	always_ff @(posedge clk) begin
		if (en[5]) begin
			bad_s5  <= bad_s4 || (secs == -44'sd1);
			hund_s5 <= hund_s4;
			secs_s5 <= secs;
		end
	end

	// stage 6: scale seconds to ticks as two partial products
	always_ff @(posedge clk) begin
		if (en[6]) begin
			bad_s6  <= bad_s5;
			hund_s6 <= hund_s5;
			lo_s6   <= {24'b0, secs_s5[21:0]} * {22'b0, TICKS_PER_SEC};
			hi_s6   <= 47'($signed(secs_s5[43:22])) * $signed({23'b0, TICKS_PER_SEC});
		end
	end

	// stage 7: join partial products, add hundredths and epoch offset
	assign tick = {18'b0, lo_s6} + ({{17{hi_s6[46]}}, hi_s6} << 22) +
	              {40'b0, hund_s6} + EPOCH_TICKS;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			bad_s7  <= bad_s6;
			tick_s7 <= bad_s6 ? 64'd0 : tick;
		end
	end

	assign res.valid     = v_q[NSTAGE];
	assign res.tick_time = tick_s7;
	assign res.status    = bad_s7 ? STATUS_INVALID : STATUS_OK;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vec.valid && vec.ready |=> v_q[1])
		else $error("accepted transaction did not reach stage 1");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> (v_q == '1))
		else $error("input blocked while a pipeline stage is empty");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == STATUS_INVALID) |-> (res.tick_time == 64'd0))
		else $error("invalid result carries nonzero tick time");
`endif

endmodule

/* rtl/dvtt_day_count.sv */
// Three-stage proleptic Gregorian day count; each stage loads on its enable.
module dvtt_day_count (
	input  logic            clk,
	input  logic [2:0]      en,
	input  logic [15:0]     year,
	input  logic [3:0]      month,
	input  logic [4:0]      day,
	output dvtt_pkg::days_t days
);
	import dvtt_pkg::*;

	logic [16:0] ya;
	logic [34:0] era_prod;
	logic [16:0] ya_s1;
	logic [7:0]  era_s1;
	logic [8:0]  doy_s1;

	logic [16:0] yoe_full;
	logic [8:0]  yoe;
	logic [17:0] cent;
	logic [17:0] doe;
	logic [7:0]  era_s2;
	logic [17:0] doe_s2;

	logic [25:0] era_days;
	days_t       days_s3;

	// stage 1: shift year into a March-based era, split off the era, form the day of year
	always_comb begin
		ya       = {1'b0, year} + 17'd400 - ((month <= 4'd2) ? 17'd1 : 17'd0);
		era_prod = {18'b0, ya} * {17'b0, ERA_RECIP};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ya_s1  <= ya;
			era_s1 <= era_prod[ERA_SHIFT+7:ERA_SHIFT];
			doy_s1 <= days_before_month(month) + {4'b0, day} - 9'd1;
		end
	end

	// stage 2: day of era from year of era and day of year
	always_comb begin
		yoe_full = ya_s1 - ({9'b0, era_s1} * 17'd400);
		yoe      = yoe_full[8:0];
		if (yoe >= 9'd300)
			cent = 18'd3;
		else if (yoe >= 9'd200)
			cent = 18'd2;
		else if (yoe >= 9'd100)
			cent = 18'd1;
		else
			cent = 18'd0;
		doe = {9'b0, yoe} * 18'd365 + {11'b0, yoe[8:2]} - cent + {9'b0, doy_s1};
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			era_s2 <= era_s1;
			doe_s2 <= doe;
		end
	end

	// stage 3: whole eras plus day of era, less the 1970 bias
	assign era_days = {18'b0, era_s2} * DAYS_PER_ERA + {8'b0, doe_s2};

	always_ff @(posedge clk) begin
		if (en[2])
			days_s3 <= $signed({1'b0, era_days}) - DAY_BIAS;
	end

	assign days = days_s3;

endmodule

/* bench/date_vector_to_tick_time_unit_tb.sv */
`timescale 1ns / 1ps

module date_vector_to_tick_time_unit_tb;
	import dvtt_pkg::*;

	localparam int              RANDOM_VECTORS = 1500;
	localparam int              STALL_LIMIT    = 2000;
	localparam int              DRAIN_CYCLES   = 20;
	localparam longint unsigned TICK_ORIGIN    = 64'h007C_9567_4BEB_4000;
	localparam longint unsigned SECOND_TICKS   = 64'd10000000;
	localparam longint unsigned HUNDREDTH_TICKS = 64'd100000;

	typedef struct packed {
		logic [15:0] year;
		logic [15:0] month;
		logic [15:0] day;
		logic [15:0] hour;
		logic [15:0] minute;
		logic [15:0] second;
		logic [15:0] hundredths;
	} calendar_t;

	typedef struct packed {
		logic [63:0] tick_time;
		logic        status;
	} tick_result_t;

	typedef struct packed {
		calendar_t    vec;
		bit           known;
		tick_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	dvtt_vec_if  vec_ch ();
	dvtt_tick_if res_ch ();

	date_vector_to_tick_time_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.res    (res_ch)
	);

	tick_result_t pending_ticks[$];
	stim_row_t    stim_table[$];
	int           mismatch_count = 0;
	bit           calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Expected tick time of one calendar vector
	function automatic tick_result_t predict_tick_time(input calendar_t c);
		longint         y, m, d, ya, era, yoe, mp, doy, doe, days, secs;
		longint unsigned hund;
		tick_result_t   r;
		r.tick_time = '0;
		r.status    = STATUS_INVALID;
		if (c.month < 1 || c.month > 12 || c.day < 1 || c.day > 31 || c.hour > 23 ||
				c.minute > 59 || c.second > 59 || c.hundredths > 99) begin
			return r;
		end
		y = longint'(c.year);
		m = longint'(c.month);
		d = longint'(c.day);
		// shift by one 400-year era so every quotient is taken on a positive value
		ya   = y + 400 - (m <= 2 ? 1 : 0);
		era  = ya / 400;
		yoe  = ya - era * 400;
		mp   = (m + 9) % 12;
		doy  = (153 * mp + 2) / 5 + d - 1;
		doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = era * 146097 + doe - 719468 - 146097;
		secs = days * 86400 + longint'(c.hour) * 3600 + longint'(c.minute) * 60 +
			longint'(c.second);
		// the second just before 1970 collides with the error marker
		if (secs == -1) begin
			return r;
		end
		hund = 64'(c.hundredths);
		r.tick_time = longint'(secs) * SECOND_TICKS + hund * HUNDREDTH_TICKS + TICK_ORIGIN;
		r.status    = STATUS_OK;
		return r;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic add_row(input logic [15:0] y, mo, d, h, mi, s, hu,
			input bit known = 1'b0, input logic [63:0] tick = '0,
			input logic status = STATUS_OK);
		stim_row_t row;
		row.vec            = '{y, mo, d, h, mi, s, hu};
		row.known          = known;
		row.want.tick_time = tick;
		row.want.status    = status;
		stim_table.push_back(row);
	endtask

	// Drive one vector, hold it until taken, then idle for a random gap, if any
	task automatic put_vector(input calendar_t c, input tick_result_t want);
		int gap;
		vec_ch.valid      <= 1'b1;
		vec_ch.year       <= c.year;
		vec_ch.month      <= c.month;
		vec_ch.day        <= c.day;
		vec_ch.hour       <= c.hour;
		vec_ch.minute     <= c.minute;
		vec_ch.second     <= c.second;
		vec_ch.hundredths <= c.hundredths;
		do @(posedge clk); while (!vec_ch.ready);
		pending_ticks.push_back(want);
		gap = pick_gap();
		if (gap > 0) begin
			vec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off the sender until every conversion is back
	task automatic drain_results();
		vec_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_ticks.size() != 0);
	endtask

	// Result side: check each transaction, stall at random
	initial begin
		int           stall_left;
		tick_result_t want;
		stall_left   = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				if (pending_ticks.size() == 0) begin
					$display("%0t: unexpected result tick_time=%h status=%b", $time,
						res_ch.tick_time, res_ch.status);
					mismatch_count++;
				end else begin
					want = pending_ticks.pop_front();
					if (res_ch.tick_time !== want.tick_time) begin
						$display("%0t: tick_time expected %h actual %h", $time,
							want.tick_time, res_ch.tick_time);
						mismatch_count++;
					end
					if (res_ch.status !== want.status) begin
						$display("%0t: status expected %b actual %b", $time,
							want.status, res_ch.status);
						mismatch_count++;
					end
				end
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int           i;
		int           roll;
		calendar_t    c;
		tick_result_t want;

		arst_n            = 1'b0;
		vec_ch.valid      = 1'b0;
		vec_ch.year       = '0;
		vec_ch.month      = '0;
		vec_ch.day        = '0;
		vec_ch.hour       = '0;
		vec_ch.minute     = '0;
		vec_ch.second     = '0;
		vec_ch.hundredths = '0;

		// epoch points, the second before 1970, every range check, extreme years and day overruns
		add_row(1970, 1, 1, 0, 0, 0, 0, 1'b1, TICK_ORIGIN, STATUS_OK);
		add_row(1858, 11, 17, 0, 0, 0, 0, 1'b1, 64'd0, STATUS_OK);
		add_row(1969, 12, 31, 23, 59, 59, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(1969, 12, 31, 23, 59, 59, 99, 1'b1, 64'd0, STATUS_INVALID);
		add_row(1969, 12, 31, 23, 59, 58, 99);
		add_row(1970, 1, 1, 0, 0, 1, 0);
		add_row(1970, 1, 1, 0, 0, 0, 99);
		add_row(2000, 0, 1, 0, 0, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 13, 1, 0, 0, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 1, 0, 0, 0, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 1, 32, 0, 0, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 1, 1, 24, 0, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 1, 1, 0, 60, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 1, 1, 0, 0, 60, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(2000, 1, 1, 0, 0, 0, 100, 1'b1, 64'd0, STATUS_INVALID);
		add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b1, 64'd0, STATUS_INVALID);
		add_row(0, 0, 0, 0, 0, 0, 0, 1'b1, 64'd0, STATUS_INVALID);
		add_row(0, 1, 1, 0, 0, 0, 0);
		add_row(16'hFFFF, 12, 31, 23, 59, 59, 99);
		add_row(2000, 2, 29, 12, 30, 30, 50);
		add_row(1900, 2, 31, 0, 0, 0, 0);
		add_row(2023, 2, 31, 23, 59, 59, 99);
		add_row(1969, 11, 31, 23, 59, 59, 0);
		add_row(1600, 3, 1, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stim_table[i]) begin
			want = stim_table[i].known ? stim_table[i].want : predict_tick_time(stim_table[i].vec);
			put_vector(stim_table[i].vec, want);
		end
		drain_results();

		// random vectors: mostly well-formed, some out of range, a few at the marker second
		for (i = 0; i < RANDOM_VECTORS; i++) begin
			calm = (i % 300) < 60;
			if (i == RANDOM_VECTORS / 2) begin
				drain_results();
			end
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				c.year = 16'($urandom_range(0, 65535));
			end else if (roll < 8) begin
				c.year = 16'($urandom_range(1900, 2100));
			end else begin
				c.year = 16'($urandom_range(1960, 1980));
			end
			c.month      = 16'($urandom_range(1, 12));
			c.day        = 16'($urandom_range(1, 31));
			c.hour       = 16'($urandom_range(0, 23));
			c.minute     = 16'($urandom_range(0, 59));
			c.second     = 16'($urandom_range(0, 59));
			c.hundredths = 16'($urandom_range(0, 99));
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				c.year   = 1969;
				c.month  = 12;
				c.day    = 31;
				c.hour   = 23;
				c.minute = 59;
				c.second = 59;
			end else if (roll < 15) begin
				// break exactly one word
				case ($urandom_range(0, 5))
					0: c.month = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(13, 65535));
					1: c.day = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(32, 65535));
					2: c.hour = 16'($urandom_range(24, 65535));
					3: c.minute = 16'($urandom_range(60, 65535));
					4: c.second = 16'($urandom_range(60, 65535));
					default: c.hundredths = 16'($urandom_range(100, 65535));
				endcase
			end
			put_vector(c, predict_tick_time(c));
		end
		calm = 1'b0;

		// wait out the pipeline, then let stray results show up
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/dvtt_pkg.sv
rtl/dvtt_vec_if.sv
rtl/dvtt_tick_if.sv
rtl/dvtt_day_count.sv
rtl/date_vector_to_tick_time_unit.sv
bench/date_vector_to_tick_time_unit_tb.sv
